FILE: design/rgbhls_pkg.sv
`timescale 1ns / 1ps
// rgbhls_pkg: opcodes, register indexes, widths and constants of the
// rgb/hls colour adjust pipeline; no dependencies
package rgbhls_pkg;

	typedef enum logic [1:0] {
		OP_RGB_TO_HLS = 2'd0,
		OP_HLS_TO_RGB = 2'd1,
		OP_ADJ_HLS    = 2'd2,
		OP_ADJ_RGB    = 2'd3
	} op_t;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 1'b1;

	localparam int DIV_NUM_W  = 30;
	localparam int DIV_DEN_W  = 22;
	localparam int DIV_Q_W    = 8;
	localparam int DIV_STAGES = 4;
	localparam int DIV_BPS    = DIV_Q_W / DIV_STAGES;

	localparam int PIPE_LAT = 9 + 2 * DIV_STAGES;

	localparam logic [DIV_DEN_W-1:0] RAMP_DEN = 22'd3901500;
	localparam logic [16:0] DEG_120 = 17'd30600;
	localparam logic [16:0] DEG_60  = 17'd15300;
	localparam logic [16:0] DEG_180 = 17'd45900;
	localparam logic [16:0] DEG_240 = 17'd61200;
	localparam logic [16:0] DEG_360 = 17'd91800;
	localparam logic [27:0] RECIP_100 = 28'd5243;
	localparam int RECIP_SHIFT = 19;

	typedef struct packed {
		op_t        op;
		logic [7:0] hue;
		logic [7:0] lit;
		logic [7:0] sat;
		logic [7:0] lit_adj;
		logic [7:0] sat_adj;
		logic       grey;
		logic       flat;
	} side_t;

endpackage

FILE: design/rgb_hls_color_adjust_core.sv
`timescale 1ns / 1ps
// rgb_hls_color_adjust_core: rgb/hls conversion and lightness/saturation adjust
// depends on rgbhls_pkg and rgbhls_div
//
// channel   handshake             payload
// input     start / busy          opcode, in_first, in_second, in_third
// result    done (strobe)         out_first, out_second, out_third
// config    cfg_write             cfg_index, cfg_data
//
// one beat accepted per clock; busy is always low
// each result is taken in order, for one cycle
// the pipeline runs through two ranks of four-stage dividers and nine other stages
// reset clears valid bits and both percent registers
// nothing stalls: the receiver takes every result
module rgb_hls_color_adjust_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           opcode,
	input  logic [7:0]                           in_first,
	input  logic [7:0]                           in_second,
	input  logic [7:0]                           in_third,
	output logic                                 done,
	output logic [7:0]                           out_first,
	output logic [7:0]                           out_second,
	output logic [7:0]                           out_third,
	input  logic                                 cfg_write,
	input  logic [rgbhls_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                           cfg_data
);

	localparam int ND = rgbhls_pkg::DIV_STAGES;

	function automatic logic rgb_in(input rgbhls_pkg::op_t op);
		return (op == rgbhls_pkg::OP_RGB_TO_HLS) || (op == rgbhls_pkg::OP_ADJ_RGB);
	endfunction

	function automatic logic adj_on(input rgbhls_pkg::op_t op);
		return (op == rgbhls_pkg::OP_ADJ_HLS) || (op == rgbhls_pkg::OP_ADJ_RGB);
	endfunction

	function automatic logic [14:0] adj_prod(input logic [7:0] v, input logic [7:0] p);
		logic [6:0] pc;
		pc = 7'd0;
		if (!p[7]) begin
			return 15'(8'd255 - v) * 15'(p[6:0]);
		end
		if ($signed(p) >= -8'sd100) begin
			pc = 7'(8'd100 + p);
		end
		return 15'(v) * 15'(pc);
	endfunction

	function automatic logic [7:0] adj_fin(input logic [7:0] v, input logic [7:0] p,
		input logic [8:0] q);
		logic [8:0] s;
		s = 9'(v) + q;
		if (p == 8'd0) begin
			return v;
		end
		if (p[7]) begin
			return q[7:0];
		end
		return (s > 9'd255) ? 8'd255 : s[7:0];
	endfunction

	function automatic logic [13:0] ramp_w(input logic [16:0] t);
		if (t < rgbhls_pkg::DEG_60) begin
			return t[13:0];
		end
		if (t < rgbhls_pkg::DEG_180) begin
			return rgbhls_pkg::DEG_60[13:0];
		end
		if (t < rgbhls_pkg::DEG_240) begin
			return 14'(rgbhls_pkg::DEG_240 - t);
		end
		return 14'd0;
	endfunction

	logic [7:0] lightness_percent_q;
	logic [7:0] saturation_percent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lightness_percent_q  <= 8'd0;
			saturation_percent_q <= 8'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				rgbhls_pkg::REG_LIGHTNESS:  lightness_percent_q  <= cfg_data;
				rgbhls_pkg::REG_SATURATION: saturation_percent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// valid bits
	logic          vld_s1, vld_s2, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic [ND-1:0] vld_a_s, vld_b_s;

	// stage 1: max, min, hue count
	rgbhls_pkg::op_t op_s1;
	logic [7:0]  a_s1, b_s1, c_s1, l_s1, d_s1;
	logic [8:0]  sum_s1;
	logic [10:0] cnt_s1;
	logic [7:0]  mx, mn, dif;
	logic [8:0]  sm;
	logic [10:0] cnt;

	always_comb begin
		mx = in_first;
		mn = in_first;
		if (in_second > mx) mx = in_second;
		if (in_third > mx) mx = in_third;
		if (in_second < mn) mn = in_second;
		if (in_third < mn) mn = in_third;
		dif = mx - mn;
		sm  = 9'(mx) + 9'(mn);
		if (in_first == mx) begin
			if (in_second > in_third) cnt = 11'(in_second - in_third);
			else cnt = 11'(dif) * 11'd6 - 11'(in_third - in_second);
		end else if (in_second == mx) begin
			cnt = 11'(dif) * 11'd2 + 11'(in_third) - 11'(in_first);
		end else begin
			cnt = 11'(dif) * 11'd4 + 11'(in_first) - 11'(in_second);
		end
	end

	always_ff @(posedge clk) begin
		op_s1  <= rgbhls_pkg::op_t'(opcode);
		a_s1   <= in_first;
		b_s1   <= in_second;
		c_s1   <= in_third;
		l_s1   <= sm[8:1];
		d_s1   <= dif;
		sum_s1 <= sm;
		cnt_s1 <= cnt;
	end

	// stage 2: divider operands
	rgbhls_pkg::side_t side_s2;
	logic [15:0] satn_s2;
	logic [8:0]  satd_s2;
	logic [18:0] huen_s2;
	logic [10:0] hued_s2;

	always_ff @(posedge clk) begin
		satn_s2 <= 16'(d_s1) * 16'd255;
		satd_s2 <= (sum_s1 <= 9'd255) ? sum_s1 : 9'd510 - sum_s1;
		huen_s2 <= 19'(cnt_s1) * 19'd255;
		hued_s2 <= 11'(d_s1) * 11'd6;
		side_s2.op      <= op_s1;
		side_s2.hue     <= a_s1;
		side_s2.lit     <= rgb_in(op_s1) ? l_s1 : b_s1;
		side_s2.sat     <= c_s1;
		side_s2.lit_adj <= 8'd0;
		side_s2.sat_adj <= 8'd0;
		side_s2.grey    <= (d_s1 == 8'd0);
		side_s2.flat    <= 1'b0;
	end

	logic [7:0] hue_q, sat_q;

	rgbhls_div u_div_hue (
		.clk (clk),
		.num (rgbhls_pkg::DIV_NUM_W'(huen_s2)),
		.den (rgbhls_pkg::DIV_DEN_W'(hued_s2)),
		.quo (hue_q)
	);

	rgbhls_div u_div_sat (
		.clk (clk),
		.num (rgbhls_pkg::DIV_NUM_W'(satn_s2)),
		.den (rgbhls_pkg::DIV_DEN_W'(satd_s2)),
		.quo (sat_q)
	);

	rgbhls_pkg::side_t side_a_s [ND];

	always_ff @(posedge clk) begin
		side_a_s[0] <= side_s2;
		for (int i = 1; i < ND; i++) begin
			side_a_s[i] <= side_a_s[i-1];
		end
	end

	rgbhls_pkg::side_t hs;

	always_comb begin
		hs = side_a_s[ND-1];
		if (rgb_in(hs.op)) begin
			hs.hue = hs.grey ? 8'd0 : hue_q;
			hs.sat = hs.grey ? 8'd0 : sat_q;
		end
	end

	// stages 7 to 9: percent adjust, divide by 100 through a reciprocal
	rgbhls_pkg::side_t side_s7, side_s8, side_s9, adj_n;
	logic [14:0] prodl_s7, prods_s7;
	logic [27:0] recl_s8, recs_s8;

	always_comb begin
		adj_n = side_s8;
		adj_n.lit_adj = adj_on(side_s8.op)
			? adj_fin(side_s8.lit, lightness_percent_q, recl_s8[rgbhls_pkg::RECIP_SHIFT +: 9])
			: side_s8.lit;
		adj_n.sat_adj = adj_on(side_s8.op)
			? adj_fin(side_s8.sat, saturation_percent_q, recs_s8[rgbhls_pkg::RECIP_SHIFT +: 9])
			: side_s8.sat;
	end

	always_ff @(posedge clk) begin
		side_s7  <= hs;
		prodl_s7 <= adj_prod(hs.lit, lightness_percent_q);
		prods_s7 <= adj_prod(hs.sat, saturation_percent_q);
		side_s8  <= side_s7;
		recl_s8  <= 28'(prodl_s7) * rgbhls_pkg::RECIP_100;
		recs_s8  <= 28'(prods_s7) * rgbhls_pkg::RECIP_100;
		side_s9  <= adj_n;
	end

	// stage 10: m1, m2 and hue angle
	rgbhls_pkg::side_t side_s10, side_s11, side_s12, side_n10;
	logic [15:0] m1_s10, diff_s10, m1_s11, diff_s11;
	logic [16:0] deg_s10;
	logic [15:0] ls;
	logic [16:0] m2, m1;

	always_comb begin
		ls = 16'(side_s9.lit_adj) * 16'(side_s9.sat_adj);
		if (side_s9.lit_adj <= 8'd127) begin
			m2 = 17'(side_s9.lit_adj) * 17'd255 + 17'(ls);
		end else begin
			m2 = 17'(side_s9.lit_adj) * 17'd255 + 17'(side_s9.sat_adj) * 17'd255 - 17'(ls);
		end
		m1 = 17'(side_s9.lit_adj) * 17'd510 - m2;
		side_n10 = side_s9;
		side_n10.flat = (side_s9.sat_adj == 8'd0);
	end

	always_ff @(posedge clk) begin
		side_s10      <= side_n10;
		m1_s10        <= m1[15:0];
		diff_s10      <= 16'(m2 - m1);
		deg_s10       <= 17'(side_s9.hue) * 17'd360;
	end

	// stage 11: ramp position per channel
	logic [13:0] w_s11 [3];
	logic [16:0] tr, tb;

	always_comb begin
		tr = deg_s10 + rgbhls_pkg::DEG_120;
		if (tr > rgbhls_pkg::DEG_360) tr = tr - rgbhls_pkg::DEG_360;
		if (deg_s10 < rgbhls_pkg::DEG_120) tb = deg_s10 + rgbhls_pkg::DEG_240;
		else tb = deg_s10 - rgbhls_pkg::DEG_120;
	end

	always_ff @(posedge clk) begin
		side_s11 <= side_s10;
		m1_s11   <= m1_s10;
		diff_s11 <= diff_s10;
		w_s11[0] <= ramp_w(tr);
		w_s11[1] <= ramp_w(deg_s10);
		w_s11[2] <= ramp_w(tb);
	end

	// stage 12: ramp numerators
	logic [rgbhls_pkg::DIV_NUM_W-1:0] num_s12 [3];

	always_ff @(posedge clk) begin
		side_s12 <= side_s11;
		for (int i = 0; i < 3; i++) begin
			num_s12[i] <= rgbhls_pkg::DIV_NUM_W'(m1_s11) * rgbhls_pkg::DIV_NUM_W'(15300)
				+ rgbhls_pkg::DIV_NUM_W'(diff_s11) * rgbhls_pkg::DIV_NUM_W'(w_s11[i]);
		end
	end

	logic [7:0] rgb_q [3];

	for (genvar g = 0; g < 3; g++) begin : g_ramp
		rgbhls_div u_div_ramp (
			.clk (clk),
			.num (num_s12[g]),
			.den (rgbhls_pkg::RAMP_DEN),
			.quo (rgb_q[g])
		);
	end

	rgbhls_pkg::side_t side_b_s [ND];

	always_ff @(posedge clk) begin
		side_b_s[0] <= side_s12;
		for (int i = 1; i < ND; i++) begin
			side_b_s[i] <= side_b_s[i-1];
		end
	end

	// output register
	rgbhls_pkg::side_t fs;
	assign fs = side_b_s[ND-1];

	always_ff @(posedge clk) begin
		unique case (fs.op)
			rgbhls_pkg::OP_RGB_TO_HLS: begin
				out_first  <= fs.hue;
				out_second <= fs.lit;
				out_third  <= fs.sat;
			end
			rgbhls_pkg::OP_ADJ_HLS: begin
				out_first  <= fs.hue;
				out_second <= fs.lit_adj;
				out_third  <= fs.sat_adj;
			end
			default: begin
				out_first  <= fs.flat ? fs.lit_adj : rgb_q[0];
				out_second <= fs.flat ? fs.lit_adj : rgb_q[1];
				out_third  <= fs.flat ? fs.lit_adj : rgb_q[2];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_a_s <= '0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_b_s <= '0;
			done    <= 1'b0;
		end else begin
			vld_s1  <= start && !busy;
			vld_s2  <= vld_s1;
			vld_a_s <= {vld_a_s[ND-2:0], vld_s2};
			vld_s7  <= vld_a_s[ND-1];
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_b_s <= {vld_b_s[ND-2:0], vld_s12};
			done    <= vld_b_s[ND-1];
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(rgbhls_pkg::PIPE_LAT) done)
		else $error("result beat missing after fixed latency");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(start && !busy, rgbhls_pkg::PIPE_LAT))
		else $error("result beat without an accepted input beat");

	a_m2_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s10 |-> (17'(m1_s10) + 17'(diff_s10) <= 17'd65025))
		else $error("m2 out of range for ramp divider");

	a_adj_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s9 && (side_s9.op == rgbhls_pkg::OP_RGB_TO_HLS
			|| side_s9.op == rgbhls_pkg::OP_HLS_TO_RGB))
		|-> (side_s9.lit_adj == side_s9.lit && side_s9.sat_adj == side_s9.sat))
		else $error("adjust applied to a plain conversion");

endmodule

FILE: design/rgbhls_div.sv
`timescale 1ns / 1ps
// rgbhls_div: pipelined restoring divider, two quotient bits per stage
// depends on rgbhls_pkg; quotient must fit in eight bits
module rgbhls_div (
	input  logic                                clk,
	input  logic [rgbhls_pkg::DIV_NUM_W-1:0]    num,
	input  logic [rgbhls_pkg::DIV_DEN_W-1:0]    den,
	output logic [rgbhls_pkg::DIV_Q_W-1:0]      quo
);

	logic [rgbhls_pkg::DIV_NUM_W-1:0] rem_s [rgbhls_pkg::DIV_STAGES];
	logic [rgbhls_pkg::DIV_DEN_W-1:0] den_s [rgbhls_pkg::DIV_STAGES];
	logic [rgbhls_pkg::DIV_Q_W-1:0]   quo_s [rgbhls_pkg::DIV_STAGES];
	logic [rgbhls_pkg::DIV_NUM_W-1:0] rem_n [rgbhls_pkg::DIV_STAGES];
	logic [rgbhls_pkg::DIV_DEN_W-1:0] den_n [rgbhls_pkg::DIV_STAGES];
	logic [rgbhls_pkg::DIV_Q_W-1:0]   quo_n [rgbhls_pkg::DIV_STAGES];

	always_comb begin
		logic [rgbhls_pkg::DIV_NUM_W-1:0] r;
		logic [rgbhls_pkg::DIV_NUM_W-1:0] t;
		logic [rgbhls_pkg::DIV_DEN_W-1:0] dd;
		logic [rgbhls_pkg::DIV_Q_W-1:0]   q;
		for (int i = 0; i < rgbhls_pkg::DIV_STAGES; i++) begin
			if (i == 0) begin
				r  = num;
				dd = den;
				q  = '0;
			end else begin
				r  = rem_s[i-1];
				dd = den_s[i-1];
				q  = quo_s[i-1];
			end
			for (int b = 0; b < rgbhls_pkg::DIV_BPS; b++) begin
				t = rgbhls_pkg::DIV_NUM_W'(dd)
					<< (rgbhls_pkg::DIV_Q_W - 1 - i * rgbhls_pkg::DIV_BPS - b);
				if (r >= t) begin
					r = r - t;
					q = q | (rgbhls_pkg::DIV_Q_W'(1)
						<< (rgbhls_pkg::DIV_Q_W - 1 - i * rgbhls_pkg::DIV_BPS - b));
				end
			end
			rem_n[i] = r;
			den_n[i] = dd;
			quo_n[i] = q;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < rgbhls_pkg::DIV_STAGES; i++) begin
			rem_s[i] <= rem_n[i];
			den_s[i] <= den_n[i];
			quo_s[i] <= quo_n[i];
		end
	end

	assign quo = quo_s[rgbhls_pkg::DIV_STAGES-1];

endmodule

FILE: bench/rgb_hls_color_adjust_core_tb.sv
`timescale 1ns / 1ps
// rgb_hls_color_adjust_core_tb: self-checking bench for the rgb/hls adjust core
// a color model predicts each triple; a scoreboard class checks results in order
// depends on rgbhls_pkg and the core rtl
module rgb_hls_color_adjust_core_tb;

	typedef struct {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} triple_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] opcode = '0;
	logic [7:0] in_first = '0, in_second = '0, in_third = '0;
	logic done;
	logic [7:0] out_first, out_second, out_third;
	logic cfg_write = 1'b0;
	logic [rgbhls_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	int errors = 0;
	int send_idle = 0;
	logic [7:0] light_pct = 8'd0, sat_pct = 8'd0;

	rgb_hls_color_adjust_core dut (.*);

	always #2 clk = ~clk;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void to_hls(input longint r, g, b, output longint h, l, s);
		longint mx, mn, d, sum, cnt;
		mx = r; mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn; sum = mx + mn;
		l = sum / 2;
		if (d == 0) begin
			h = 0; s = 0;
		end else begin
			s = (sum <= 255) ? (255 * d) / sum : (255 * d) / (510 - sum);
			if (r == mx) begin
				cnt = 6 * d + (g - b);
				if (cnt > 6 * d) cnt -= 6 * d;
			end else if (g == mx) cnt = 2 * d + (b - r);
			else cnt = 4 * d + (r - g);
			h = (cnt * 255) / (6 * d);
		end
	endfunction

	function automatic longint ramp(input longint m1, m2, longint deg);
		if (deg > 91800) deg -= 91800;
		else if (deg < 0) deg += 91800;
		if (deg < 15300) return (m1 * 15300 + (m2 - m1) * deg) / (15300 * 255);
		if (deg < 45900) return m2 / 255;
		if (deg < 61200) return (m1 * 15300 + (m2 - m1) * (61200 - deg)) / (15300 * 255);
		return m1 / 255;
	endfunction

	function automatic void to_rgb(input longint h, l, s, output longint r, g, b);
		longint m1, m2, deg;
		if (s == 0) begin
			r = l; g = l; b = l;
		end else begin
			deg = h * 360;
			if (l <= 127) m2 = l * 255 + l * s;
			else m2 = l * 255 + s * 255 - l * s;
			m1 = 2 * l * 255 - m2;
			r = ramp(m1, m2, deg + 30600);
			g = ramp(m1, m2, deg);
			b = ramp(m1, m2, deg - 30600);
		end
	endfunction

	function automatic longint nudge(input longint v, longint p);
		if (p > 0) begin
			v += ((255 - v) * p) / 100;
			if (v > 255) v = 255;
		end else if (p < 0) begin
			if (p < -100) p = -100;
			v = (v * (100 + p)) / 100;
		end
		return v;
	endfunction

	function automatic triple_t predict_color(input rgbhls_pkg::op_t op, input triple_t t);
		longint x, y, z, h, l, s, pl, ps;
		triple_t o;
		pl = longint'($signed(light_pct));
		ps = longint'($signed(sat_pct));
		x = t.a; y = t.b; z = t.c;
		case (op)
			rgbhls_pkg::OP_RGB_TO_HLS: to_hls(t.a, t.b, t.c, x, y, z);
			rgbhls_pkg::OP_HLS_TO_RGB: to_rgb(t.a, t.b, t.c, x, y, z);
			rgbhls_pkg::OP_ADJ_HLS: begin
				y = nudge(t.b, pl);
				z = nudge(t.c, ps);
			end
			default: begin
				to_hls(t.a, t.b, t.c, h, l, s);
				to_rgb(h, nudge(l, pl), nudge(s, ps), x, y, z);
			end
		endcase
		o.a = x[7:0]; o.b = y[7:0]; o.c = z[7:0];
		return o;
	endfunction

	class color_scoreboard;
		triple_t pending[$];

		function void note_beat(triple_t t);
			pending.push_back(t);
		endfunction

		task check_result(triple_t got);
			triple_t want;
			if (pending.size() == 0) begin
				report("unexpected result", got.a, -1);
				return;
			end
			want = pending.pop_front();
			if (got.a !== want.a) report("out_first", got.a, want.a);
			if (got.b !== want.b) report("out_second", got.b, want.b);
			if (got.c !== want.c) report("out_third", got.c, want.c);
		endtask
	endclass

	color_scoreboard sb = new();

	always @(posedge clk) begin
		triple_t t;
		if (arst_n && start && !busy) begin
			t.a = in_first; t.b = in_second; t.c = in_third;
			sb.note_beat(predict_color(rgbhls_pkg::op_t'(opcode), t));
		end
		if (arst_n && done) begin
			t.a = out_first; t.b = out_second; t.c = out_third;
			sb.check_result(t);
		end
	end

	task automatic send_beat(input rgbhls_pkg::op_t op, input logic [7:0] a, b, c);
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		opcode <= op; in_first <= a; in_second <= b; in_third <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (rgbhls_pkg::PIPE_LAT + 4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [rgbhls_pkg::CFG_IDX_W-1:0] idx,
		input logic [7:0] val);
		cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == rgbhls_pkg::REG_LIGHTNESS) light_pct = val;
		else sat_pct = val;
		@(negedge clk);
	endtask

	task automatic random_beats(input int n);
		rgbhls_pkg::op_t op;
		for (int i = 0; i < n; i++) begin
			op = rgbhls_pkg::op_t'($urandom_range(3));
			send_beat(op, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	function automatic logic [7:0] rand_pct();
		case ($urandom_range(5))
			0: return 8'sd100;
			1: return -8'sd100;
			2: return 8'd0;
			3: return 8'($urandom);
			default: return 8'($signed($urandom_range(200)) - 100);
		endcase
	endfunction

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_beat(rgbhls_pkg::OP_RGB_TO_HLS, 8'd0, 8'd0, 8'd0);
		send_beat(rgbhls_pkg::OP_RGB_TO_HLS, 8'd255, 8'd255, 8'd255);
		send_beat(rgbhls_pkg::OP_RGB_TO_HLS, 8'd255, 8'd0, 8'd0);
		send_beat(rgbhls_pkg::OP_RGB_TO_HLS, 8'd200, 8'd50, 8'd50);
		send_beat(rgbhls_pkg::OP_RGB_TO_HLS, 8'd0, 8'd255, 8'd0);
		send_beat(rgbhls_pkg::OP_RGB_TO_HLS, 8'd0, 8'd0, 8'd255);
		send_beat(rgbhls_pkg::OP_RGB_TO_HLS, 8'd255, 8'd10, 8'd20);
		send_beat(rgbhls_pkg::OP_HLS_TO_RGB, 8'd0, 8'd128, 8'd0);
		send_beat(rgbhls_pkg::OP_HLS_TO_RGB, 8'd255, 8'd255, 8'd255);
		send_beat(rgbhls_pkg::OP_HLS_TO_RGB, 8'd0, 8'd0, 8'd255);
		send_beat(rgbhls_pkg::OP_HLS_TO_RGB, 8'd85, 8'd127, 8'd255);
		send_beat(rgbhls_pkg::OP_HLS_TO_RGB, 8'd170, 8'd128, 8'd200);
		send_beat(rgbhls_pkg::OP_ADJ_HLS, 8'd17, 8'd200, 8'd30);
		send_beat(rgbhls_pkg::OP_ADJ_RGB, 8'd30, 8'd90, 8'd250);
		drain();
		write_reg(rgbhls_pkg::REG_LIGHTNESS, 8'sd100);
		write_reg(rgbhls_pkg::REG_SATURATION, -8'sd100);
		send_beat(rgbhls_pkg::OP_ADJ_HLS, 8'd0, 8'd0, 8'd255);
		send_beat(rgbhls_pkg::OP_ADJ_RGB, 8'd10, 8'd200, 8'd90);
		drain();
		write_reg(rgbhls_pkg::REG_LIGHTNESS, 8'h80);
		write_reg(rgbhls_pkg::REG_SATURATION, 8'h7f);
		send_beat(rgbhls_pkg::OP_ADJ_HLS, 8'd0, 8'd255, 8'd128);
		send_beat(rgbhls_pkg::OP_ADJ_RGB, 8'd255, 8'd1, 8'd128);
		drain();
		send_idle = 18;
		for (int ph = 0; ph < 15; ph++) begin
			if (ph == 5) send_idle = 59;
			if (ph == 10) send_idle = 0;
			write_reg(rgbhls_pkg::REG_LIGHTNESS, rand_pct());
			write_reg(rgbhls_pkg::REG_SATURATION, rand_pct());
			random_beats(115);
			drain();
		end
		if (errors == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
